@@ hw/rtl/bids_pkg.sv @@
// Shared types and constants for the bilinear image downscaler.
// Used by every module under hw/rtl; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bids_pkg;
  localparam int LINE_MAX_DEF  = 1024;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FRAC_MAX      = 16;
  localparam int WGT_W         = FRAC_MAX + 1;
  localparam int QDEPTH        = 2;

  localparam logic [2:0] REG_SRC_HEIGHT = 3'd0;
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd1;
  localparam logic [2:0] REG_PERCENT    = 3'd2;
  localparam logic [2:0] REG_ROW_STEP   = 3'd3;
  localparam logic [2:0] REG_COL_STEP   = 3'd4;

  // ceil(2^31 / 100): exact floor division by 100 for 24-bit dividends
  localparam logic [24:0] RECIP_100 = 25'd21474837;
  localparam int          RECIP_SH  = 31;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } pix_out_t;

  typedef struct packed {
    logic [23:0]      p1;
    logic [23:0]      p2;
    logic [23:0]      p3;
    logic [23:0]      p4;
    logic [WGT_W-1:0] fx;
    logic [WGT_W-1:0] fy;
    logic             last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic {FE_IDLE, FE_EVAL} fe_state_t;
endpackage
`default_nettype wire

@@ hw/rtl/bids_queue.sv @@
// Two-entry job queue between front and back.
// Depends on bids_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bids_queue import bids_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire job_t    din,
  input  wire logic    pop,
  output job_t         dout,
  output q_stat_t      stat
);
  job_t       mem [QDEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  assign dout       = mem[rd_ptr];
  assign stat.full  = (count == 2'(QDEPTH));
  assign stat.empty = (count == 2'd0);
endmodule
`default_nettype wire

@@ hw/rtl/bids_front.sv @@
// Front end: config registers, source/destination counters, line store,
// tap selection and job issue. Depends on bids_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bids_front import bids_pkg::*; #(
  parameter int LINE_MAX  = LINE_MAX_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire pix_in_t in_data,
  input  wire logic    cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [22:0] cfg_data,
  input  wire q_stat_t q_stat,
  output logic         push,
  output job_t         job
);
  localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  fe_state_t   state, state_next;
  logic [1:0]  settle;
  logic [15:0] src_height;
  logic [10:0] src_width;
  logic [7:0]  percent;
  logic [22:0] row_step, col_step;
  logic [15:0] src_row, src_col, dst_row, dst_col;
  logic [31:0] row_pos, col_pos;
  logic [23:0] above_left, left_pixel, pix;
  logic [23:0] mem [LINE_MAX];
  logic [23:0] rd;
  logic [23:0] prod_h, prod_w;
  logic [15:0] dh, dw;
  logic        bypass;
  logic        eval;

  logic [15:0] h_eff, hm1, w_eff, wm1;
  logic [16:0] wext;
  logic [48:0] qh, qw;
  logic [15:0] y1, x1, y2, x2;
  logic        col_in, last_src, fire, yc, xc;
  logic [23:0] b, p1, p2, p3;
  logic [WGT_W-1:0] one, fx, fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FE_IDLE;
      settle     <= 2'd3;
      src_height <= 16'd240;
      src_width  <= 11'd192;
      percent    <= 8'd50;
      row_step   <= 23'd131072;
      col_step   <= 23'd131072;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        settle <= 2'd3;
        unique case (cfg_index)
          REG_SRC_HEIGHT: src_height <= cfg_data[15:0];
          REG_SRC_WIDTH:  src_width  <= cfg_data[10:0];
          REG_PERCENT:    percent    <= cfg_data[7:0];
          REG_ROW_STEP:   row_step   <= cfg_data;
          REG_COL_STEP:   col_step   <= cfg_data;
          default: ;
        endcase
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FE_IDLE: if (in_valid && in_ready) state_next = FE_EVAL;
      FE_EVAL: state_next = FE_IDLE;
      default: state_next = FE_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == FE_IDLE) && !q_stat.full && (settle == 2'd0);
    eval     = (state == FE_EVAL);
  end

  // effective sizes and scaled output sizes
  always_comb begin
    h_eff = (src_height == 16'd0) ? 16'd1 : src_height;
    hm1   = h_eff - 16'd1;
    wext  = {6'd0, src_width};
    if (wext == 17'd0) wext = 17'd1;
    if (wext > 17'(LINE_MAX)) wext = 17'(LINE_MAX);
    w_eff = wext[15:0];
    wm1   = w_eff - 16'd1;
    qh    = 49'(prod_h) * 49'(RECIP_100);
    qw    = 49'(prod_w) * 49'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    prod_h <= 24'(h_eff) * 24'(percent);
    prod_w <= 24'(w_eff) * 24'(percent);
    dh     <= qh[RECIP_SH+15:RECIP_SH];
    dw     <= qw[RECIP_SH+15:RECIP_SH];
    bypass <= (percent == 8'd0) || (percent >= 8'd100)
              || (qh[RECIP_SH+15:RECIP_SH] == 16'd0)
              || (qw[RECIP_SH+15:RECIP_SH] == 16'd0);
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) pix <= in_data;
  end

  always_ff @(posedge clk) begin
    if (eval && col_in) mem[src_col[AW-1:0]] <= pix;
    rd <= mem[src_col[AW-1:0]];
  end

  always_comb begin
    col_in   = 17'(src_col) < 17'(LINE_MAX);
    b        = col_in ? rd : 24'd0;
    last_src = (src_row >= hm1) && (src_col >= wm1);
    y1 = row_pos[31:16];
    if (y1 > hm1) y1 = hm1;
    x1 = col_pos[31:16];
    if (x1 > wm1) x1 = wm1;
    y2 = ((17'(y1) + 17'd1) > 17'(hm1)) ? hm1 : y1 + 16'd1;
    x2 = ((17'(x1) + 17'd1) > 17'(wm1)) ? wm1 : x1 + 16'd1;
    yc = (y1 == y2);
    xc = (x1 == x2);
    fire = !bypass && (dst_row < dh) && (dst_col < dw)
           && (src_row == y2) && (src_col == x2);
    p2 = yc ? pix : b;
    p3 = xc ? pix : left_pixel;
    p1 = xc ? p2 : (yc ? left_pixel : above_left);
    one = WGT_W'(1) << FRAC_BITS;
    fx  = WGT_W'(col_pos[15:0] >> (16 - FRAC_BITS));
    fy  = WGT_W'(row_pos[15:0] >> (16 - FRAC_BITS));
    push = eval && (bypass || fire);
    if (bypass) begin
      job.p1 = 24'd0;
      job.p2 = 24'd0;
      job.p3 = 24'd0;
      job.fx = one;
      job.fy = one;
      job.last = last_src;
    end else begin
      job.p1 = p1;
      job.p2 = p2;
      job.p3 = p3;
      job.fx = fx;
      job.fy = fy;
      job.last = (dst_row == dh - 16'd1) && (dst_col == dw - 16'd1);
    end
    job.p4 = pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_row    <= 16'd0;
      src_col    <= 16'd0;
      dst_row    <= 16'd0;
      dst_col    <= 16'd0;
      row_pos    <= 32'd0;
      col_pos    <= 32'd0;
      above_left <= 24'd0;
      left_pixel <= 24'd0;
    end else if (eval) begin
      above_left <= b;
      left_pixel <= pix;
      if (last_src) begin
        src_row <= 16'd0;
        src_col <= 16'd0;
        dst_row <= 16'd0;
        dst_col <= 16'd0;
        row_pos <= 32'd0;
        col_pos <= 32'd0;
      end else begin
        if (fire) begin
          if ((17'(dst_col) + 17'd1) >= 17'(dw)) begin
            dst_col <= 16'd0;
            col_pos <= 32'd0;
            dst_row <= dst_row + 16'd1;
            row_pos <= row_pos + 32'(row_step);
          end else begin
            dst_col <= dst_col + 16'd1;
            col_pos <= col_pos + 32'(col_step);
          end
        end
        if ((17'(src_col) + 17'd1) >= 17'(w_eff)) begin
          src_col <= 16'd0;
          src_row <= src_row + 16'd1;
        end else begin
          src_col <= src_col + 16'd1;
        end
      end
    end
  end

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == FE_EVAL))
    else $error("accepted transfer not evaluated");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full queue");
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> !in_ready)
    else $error("input taken before config settled");
endmodule
`default_nettype wire

@@ hw/rtl/bids_back.sv @@
// Back end: weight products, weighted channel sums and output register.
// Depends on bids_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bids_back import bids_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire job_t    job,
  input  wire q_stat_t q_stat,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output pix_out_t     out_data
);
  localparam int PW = 2 * WGT_W;
  localparam int SW = PW + 10;

  logic             a_valid, a_move, o_move;
  logic [PW-1:0]    w1, w2, w3, w4;
  logic [23:0]      a_p1, a_p2, a_p3, a_p4;
  logic             a_last;
  logic [WGT_W-1:0] one, nfx, nfy;
  logic [SW-1:0]    sr, sg, sb;

  function automatic logic [SW-1:0] wsum(input logic [7:0] c1, c2, c3, c4,
                                         input logic [PW-1:0] k1, k2, k3, k4);
    wsum = SW'(c1) * SW'(k1) + SW'(c2) * SW'(k2)
         + SW'(c3) * SW'(k3) + SW'(c4) * SW'(k4);
  endfunction

  always_comb begin
    one    = WGT_W'(1) << FRAC_BITS;
    nfx    = one - job.fx;
    nfy    = one - job.fy;
    o_move = !out_valid || out_ready;
    a_move = a_valid && o_move;
    pop    = !q_stat.empty && (!a_valid || a_move);
    sr = wsum(a_p1[23:16], a_p2[23:16], a_p3[23:16], a_p4[23:16], w1, w2, w3, w4);
    sg = wsum(a_p1[15:8], a_p2[15:8], a_p3[15:8], a_p4[15:8], w1, w2, w3, w4);
    sb = wsum(a_p1[7:0], a_p2[7:0], a_p3[7:0], a_p4[7:0], w1, w2, w3, w4);
    sr = sr >> (2 * FRAC_BITS);
    sg = sg >> (2 * FRAC_BITS);
    sb = sb >> (2 * FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) a_valid <= 1'b1;
      else if (a_move) a_valid <= 1'b0;
      if (a_move) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w1     <= PW'(nfx) * PW'(nfy);
      w2     <= PW'(job.fx) * PW'(nfy);
      w3     <= PW'(nfx) * PW'(job.fy);
      w4     <= PW'(job.fx) * PW'(job.fy);
      a_p1   <= job.p1;
      a_p2   <= job.p2;
      a_p3   <= job.p3;
      a_p4   <= job.p4;
      a_last <= job.last;
    end
    if (a_move) begin
      out_data.out_red   <= sr[7:0];
      out_data.out_green <= sg[7:0];
      out_data.out_blue  <= sb[7:0];
      out_data.frame_end <= a_last;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/bilinear_image_downscaler_top.sv @@
// Top level of the bilinear image downscaler: front, job queue, back.
// Depends on bids_pkg, bids_front, bids_queue, bids_back.
//
//   channel  | signals                                 | transfer when
//   input    | in_valid, in_ready, in_data             | in_valid & in_ready
//   output   | out_valid, out_ready, out_data          | out_valid & out_ready
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// The front takes a source pixel while idle and the queue has room, then
// spends an evaluate state on the registered line store read, tap selection
// and counter update before it takes the next. A result goes from its source
// pixel through a 2-entry queue and a 2-stage back end (weights, then weighted
// sums); output stalls back up the queue. After reset or a config write the
// input holds off while a settle counter runs down and the output sizes are
// recomputed. Reset is synchronous; the line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_image_downscaler_top import bids_pkg::*; #(
  parameter int LINE_MAX  = LINE_MAX_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire pix_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output pix_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [22:0] cfg_data
);
  job_t    f_job, q_job;
  logic    push, pop;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  bids_front #(.LINE_MAX(LINE_MAX), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .cfg_valid, .cfg_index, .cfg_data,
    .q_stat, .push, .job(f_job)
  );

  bids_queue u_queue (
    .clk, .rst, .push, .din(f_job), .pop, .dout(q_job), .stat(q_stat)
  );

  bids_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .job(q_job), .q_stat, .pop, .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire
